// ===== design/filled_sprite_quad_generator_top_macros.svh =====
// Assertion macros for the filled sprite quad generator.
// Used by design files that check their own logic; needs clk and arst_n in scope.
`ifndef FILLED_SPRITE_QUAD_GENERATOR_TOP_MACROS_SVH
`define FILLED_SPRITE_QUAD_GENERATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FSQG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FSQG_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FSQG_ASSERT(label, prop, msg)
`define FSQG_NEVER(label, cond, msg)
`endif
`endif

// ===== design/fsqg_pkg.sv =====
// Shared types, constants and small functions of the filled sprite quad generator.
// No dependencies; imported by every module of the block.
package fsqg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE_I     = 1 << FRAC_BITS;

	localparam logic [16:0] ONE_V  = 17'(ONE_I);
	localparam logic [16:0] HALF_V = 17'(ONE_I / 2);
	// Smallest value that is not below 0.001, largest that is not above 0.999.
	localparam logic [16:0] LO_V   = 17'((ONE_I + 999) / 1000);
	localparam logic [16:0] HI_V   = 17'((999 * ONE_I) / 1000);

	localparam logic [1:0] METHOD_HORIZ  = 2'd0;
	localparam logic [1:0] METHOD_VERT   = 2'd1;
	localparam logic [1:0] METHOD_RADIAL = 2'd2;

	localparam logic REG_FILL_METHOD   = 1'b0;
	localparam logic REG_RADIAL_INVERT = 1'b1;

	typedef struct packed {
		logic signed [31:0] x0;
		logic signed [31:0] y0;
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic [16:0]        fill;
		logic [1:0]         method;
		logic               inv;
		logic [1:0]         bc;
		logic [1:0]         corner;
		logic [1:0]         quad;
		logic               last;
	} job_t;

	// Tangent over 0..45 degrees in 16 steps, Q0.16; out of range reads as 1.0.
	function automatic logic [16:0] tan_lut(input logic [4:0] idx);
		logic [16:0] r;
		unique case (idx)
			5'd0:    r = 17'd0;
			5'd1:    r = 17'd3220;
			5'd2:    r = 17'd6455;
			5'd3:    r = 17'd9721;
			5'd4:    r = 17'd13036;
			5'd5:    r = 17'd16415;
			5'd6:    r = 17'd19880;
			5'd7:    r = 17'd23450;
			5'd8:    r = 17'd27146;
			5'd9:    r = 17'd30994;
			5'd10:   r = 17'd35030;
			5'd11:   r = 17'd39279;
			5'd12:   r = 17'd43790;
			5'd13:   r = 17'd48605;
			5'd14:   r = 17'd53784;
			5'd15:   r = 17'd59398;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// Share of the fill that falls into one quarter, clamped to 0..ONE.
	function automatic logic [16:0] quarter_val(input logic [16:0] fill, input logic inv,
			input logic [1:0] bc);
		logic [1:0]  kk;
		logic [18:0] v4;
		logic [18:0] off;
		logic [18:0] d;
		kk  = inv ? bc : ~bc;
		v4  = {fill, 2'b00};
		off = {1'b0, kk, 16'd0};
		d   = v4 - off;
		if (v4 < off) begin
			return 17'd0;
		end
		if (d > {2'b00, ONE_V}) begin
			return ONE_V;
		end
		return d[16:0];
	endfunction

	function automatic logic [1:0] low_bit(input logic [3:0] m);
		logic [1:0] r;
		priority if (m[0]) r = 2'd0;
		else if (m[1]) r = 2'd1;
		else if (m[2]) r = 2'd2;
		else r = 2'd3;
		return r;
	endfunction

endpackage

// ===== design/fsqg_issue.sv =====
// Input sequencer: takes one rectangle and issues one vertex job per cycle.
// Depends on fsqg_pkg.
module fsqg_issue import fsqg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] rect_left,
	input  logic signed [31:0] rect_bottom,
	input  logic signed [31:0] rect_right,
	input  logic signed [31:0] rect_top,
	input  logic [16:0]        fill_amount,
	input  logic [1:0]         method,
	input  logic               invert,
	output logic               busy,
	output logic               job_valid,
	output job_t               job
);

	logic               act_q;
	logic [3:0]         rem_q;
	logic [1:0]         bc_q;
	logic [1:0]         corner_q;
	logic [1:0]         quad_q;
	logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
	logic [16:0]        fill_q;
	logic [1:0]         method_q;
	logic               inv_q;

	logic [3:0] mask;
	logic       fill_ok;
	logic       final_job;
	logic       accept;

	// Quarters that carry vertices for the incoming item.
	always_comb begin
		fill_ok = (fill_amount >= LO_V) && (fill_amount <= ONE_V);
		mask    = 4'b0000;
		if (fill_ok) begin
			if (fill_amount == ONE_V || method == METHOD_HORIZ || method == METHOD_VERT) begin
				mask = 4'b0001;
			end else if (method == METHOD_RADIAL) begin
				for (int b = 0; b < 4; b++) begin
					mask[b] = quarter_val(fill_amount, invert, 2'(b)) >= LO_V;
				end
			end
		end
	end

	assign final_job = (corner_q == 2'd3) && (rem_q == 4'b0000);
	assign busy      = act_q && !final_job;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			rem_q    <= 4'b0000;
			bc_q     <= 2'd0;
			corner_q <= 2'd0;
			quad_q   <= 2'd0;
		end else if (accept) begin
			act_q    <= mask != 4'b0000;
			bc_q     <= low_bit(mask);
			rem_q    <= mask & ~(4'b0001 << low_bit(mask));
			corner_q <= 2'd0;
			quad_q   <= 2'd0;
		end else if (act_q) begin
			if (corner_q == 2'd3) begin
				if (rem_q == 4'b0000) begin
					act_q <= 1'b0;
				end else begin
					bc_q   <= low_bit(rem_q);
					rem_q  <= rem_q & ~(4'b0001 << low_bit(rem_q));
					quad_q <= quad_q + 2'd1;
				end
			end
			corner_q <= corner_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q     <= rect_left;
			y0_q     <= rect_bottom;
			x1_q     <= rect_right;
			y1_q     <= rect_top;
			fill_q   <= fill_amount;
			method_q <= method;
			inv_q    <= invert;
		end
	end

	always_comb begin
		job.x0     = x0_q;
		job.y0     = y0_q;
		job.x1     = x1_q;
		job.y1     = y1_q;
		job.fill   = fill_q;
		job.method = method_q;
		job.inv    = inv_q;
		job.bc     = bc_q;
		job.corner = corner_q;
		job.quad   = quad_q;
		job.last   = final_job;
	end
	assign job_valid = act_q;

endmodule

// ===== design/fsqg_pipe.sv =====
// Vertex pipeline: angle ratio, quad corners, interpolation products, final select.
// Depends on fsqg_pkg; fed one job per cycle by fsqg_issue.
module fsqg_pipe import fsqg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  job_t               job,
	output logic               res_valid,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic [16:0]        res_u,
	output logic [16:0]        res_v,
	output logic [1:0]         res_quad,
	output logic [1:0]         res_corner,
	output logic               res_last
);

	function automatic logic [31:0] pick_x(input logic [1:0] j, input logic [31:0] a,
			input logic [31:0] b);
		return j[1] ? b : a;
	endfunction

	function automatic logic [31:0] pick_y(input logic [1:0] j, input logic [31:0] a,
			input logic [31:0] b);
		return (j[1] ^ j[0]) ? b : a;
	endfunction

	// Stage 1 logic: quarter value, cut direction, table fetch, midpoint.
	logic               radial1, ci1, cut1, gt1, lt1;
	logic [16:0]        v1, a1, arg1, lo1, hi1;
	logic [4:0]         idx1;
	logic signed [32:0] dxh1, dyh1;

	always_comb begin
		radial1 = (job.method == METHOD_RADIAL) && (job.fill != ONE_V);
		v1      = quarter_val(job.fill, job.inv, job.bc);
		ci1     = job.inv ^ job.bc[0];
		cut1    = ci1 || (v1 <= HI_V);
		a1      = ci1 ? (ONE_V - v1) : v1;
		gt1     = a1 > HALF_V;
		lt1     = a1 < HALF_V;
		arg1    = gt1 ? (ONE_V - a1) : a1;
		idx1    = arg1[15:11];
		lo1     = tan_lut(idx1);
		hi1     = tan_lut(idx1 + 5'd1);
		dxh1    = ($signed({job.x1[31], job.x1}) - $signed({job.x0[31], job.x0})) >>> 1;
		dyh1    = ($signed({job.y1[31], job.y1}) - $signed({job.y0[31], job.y0})) >>> 1;
	end

	logic               s2_v;
	job_t               s2_job;
	logic               s2_radial, s2_ci, s2_cut, s2_gt, s2_lt;
	logic [16:0]        s2_lo;
	logic [12:0]        s2_dlt;
	logic [15:0]        s2_frac;
	logic signed [31:0] s2_xm, s2_ym;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		s2_job    <= job;
		s2_radial <= radial1;
		s2_ci     <= ci1;
		s2_cut    <= cut1;
		s2_gt     <= gt1;
		s2_lt     <= lt1;
		s2_lo     <= lo1;
		s2_dlt    <= 13'(hi1 - lo1);
		s2_frac   <= {arg1[10:0], 5'd0};
		s2_xm     <= job.x0 + dxh1[31:0];
		s2_ym     <= job.y0 + dyh1[31:0];
	end

	// Stage 2 logic: interpolated ratio, quarter corners, mix operands and flags.
	logic [28:0] rprod2;
	logic [16:0] ratio2, tx2, ty2;
	logic [31:0] xa2, xb2, ya2, yb2, ua2, ub2, va2, vb2;
	logic [1:0]  c2, rel2;
	logic        mx2, my2, ca2, cb2;
	logic [31:0] xp0_2, xp2_2, yp0_2, yp2_2, up0_2, up2_2, vp0_2, vp2_2;

	always_comb begin
		rprod2 = s2_dlt * s2_frac;
		ratio2 = s2_lo + {4'd0, rprod2[28:16]};
		if (s2_radial) begin
			tx2 = s2_gt ? ratio2 : ONE_V;
			ty2 = s2_lt ? ratio2 : ONE_V;
		end else begin
			tx2 = (s2_job.method == METHOD_HORIZ) ? s2_job.fill : ONE_V;
			ty2 = (s2_job.method == METHOD_VERT) ? s2_job.fill : ONE_V;
		end

		xa2 = s2_job.x0;
		xb2 = s2_job.x1;
		ya2 = s2_job.y0;
		yb2 = s2_job.y1;
		ua2 = 32'd0;
		ub2 = {15'd0, ONE_V};
		va2 = 32'd0;
		vb2 = {15'd0, ONE_V};
		if (s2_radial) begin
			if (s2_job.bc[1]) begin
				xa2 = s2_xm;
				ua2 = {15'd0, HALF_V};
			end else begin
				xb2 = s2_xm;
				ub2 = {15'd0, HALF_V};
			end
			if (s2_job.bc[1] ^ s2_job.bc[0]) begin
				ya2 = s2_ym;
				va2 = {15'd0, HALF_V};
			end else begin
				yb2 = s2_ym;
				vb2 = {15'd0, HALF_V};
			end
		end

		c2   = s2_radial ? (s2_job.bc + 2'd2) : 2'd0;
		rel2 = s2_job.corner - c2;
		ca2  = s2_gt && s2_ci;
		cb2  = s2_lt && !s2_ci;
		if (!s2_radial) begin
			mx2 = s2_job.corner[1];
			my2 = s2_job.corner[1] ^ s2_job.corner[0];
		end else if (!s2_cut) begin
			mx2 = 1'b0;
			my2 = 1'b0;
		end else if (c2[0]) begin
			mx2 = (ca2 && (rel2 == 2'd1 || rel2 == 2'd2)) || (!s2_ci && rel2 == 2'd3);
			my2 = (cb2 && (rel2 == 2'd2 || rel2 == 2'd3)) || (s2_ci && rel2 == 2'd1);
		end else begin
			my2 = (cb2 && (rel2 == 2'd1 || rel2 == 2'd2)) || (s2_ci && rel2 == 2'd3);
			mx2 = (ca2 && (rel2 == 2'd2 || rel2 == 2'd3)) || (!s2_ci && rel2 == 2'd1);
		end

		xp0_2 = pick_x(c2, xa2, xb2);
		xp2_2 = pick_x(c2 + 2'd2, xa2, xb2);
		yp0_2 = pick_y(c2, ya2, yb2);
		yp2_2 = pick_y(c2 + 2'd2, ya2, yb2);
		up0_2 = pick_x(c2, ua2, ub2);
		up2_2 = pick_x(c2 + 2'd2, ua2, ub2);
		vp0_2 = pick_y(c2, va2, vb2);
		vp2_2 = pick_y(c2 + 2'd2, va2, vb2);
	end

	logic               s3_v;
	logic [16:0]        s3_tx, s3_ty;
	logic signed [32:0] s3_dx, s3_dy;
	logic signed [17:0] s3_du, s3_dv;
	logic signed [31:0] s3_xp0, s3_yp0, s3_xk, s3_yk;
	logic [16:0]        s3_up0, s3_vp0, s3_uk, s3_vk;
	logic               s3_mx, s3_my;
	logic [1:0]         s3_quad, s3_corner;
	logic               s3_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else begin
			s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		s3_tx     <= tx2;
		s3_ty     <= ty2;
		s3_dx     <= $signed({xp2_2[31], xp2_2}) - $signed({xp0_2[31], xp0_2});
		s3_dy     <= $signed({yp2_2[31], yp2_2}) - $signed({yp0_2[31], yp0_2});
		s3_du     <= $signed({1'b0, up2_2[16:0]}) - $signed({1'b0, up0_2[16:0]});
		s3_dv     <= $signed({1'b0, vp2_2[16:0]}) - $signed({1'b0, vp0_2[16:0]});
		s3_xp0    <= xp0_2;
		s3_yp0    <= yp0_2;
		s3_up0    <= up0_2[16:0];
		s3_vp0    <= vp0_2[16:0];
		s3_xk     <= pick_x(s2_job.corner, xa2, xb2);
		s3_yk     <= pick_y(s2_job.corner, ya2, yb2);
		s3_uk     <= 17'(pick_x(s2_job.corner, ua2, ub2));
		s3_vk     <= 17'(pick_y(s2_job.corner, va2, vb2));
		s3_mx     <= mx2;
		s3_my     <= my2;
		s3_quad   <= s2_job.quad;
		s3_corner <= s2_job.corner;
		s3_last   <= s2_job.last;
	end

	// Stage 3: one product per coordinate lane.
	logic               s4_v;
	logic signed [50:0] s4_px, s4_py;
	logic signed [35:0] s4_pu, s4_pv;
	logic signed [31:0] s4_xp0, s4_yp0, s4_xk, s4_yk;
	logic [16:0]        s4_up0, s4_vp0, s4_uk, s4_vk;
	logic               s4_mx, s4_my;
	logic [1:0]         s4_quad, s4_corner;
	logic               s4_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_v <= 1'b0;
		end else begin
			s4_v <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		s4_px     <= s3_dx * $signed({1'b0, s3_tx});
		s4_py     <= s3_dy * $signed({1'b0, s3_ty});
		s4_pu     <= s3_du * $signed({1'b0, s3_tx});
		s4_pv     <= s3_dv * $signed({1'b0, s3_ty});
		s4_xp0    <= s3_xp0;
		s4_yp0    <= s3_yp0;
		s4_up0    <= s3_up0;
		s4_vp0    <= s3_vp0;
		s4_xk     <= s3_xk;
		s4_yk     <= s3_yk;
		s4_uk     <= s3_uk;
		s4_vk     <= s3_vk;
		s4_mx     <= s3_mx;
		s4_my     <= s3_my;
		s4_quad   <= s3_quad;
		s4_corner <= s3_corner;
		s4_last   <= s3_last;
	end

	// Stage 4: floor the products, add the base point and pick the corner value.
	logic [31:0] mx4, my4;
	logic [16:0] mu4, mv4;

	always_comb begin
		mx4 = s4_xp0 + s4_px[47:16];
		my4 = s4_yp0 + s4_py[47:16];
		mu4 = s4_up0 + s4_pu[32:16];
		mv4 = s4_vp0 + s4_pv[32:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= s4_v;
		end
	end

	always_ff @(posedge clk) begin
		res_x      <= s4_mx ? mx4 : s4_xk;
		res_y      <= s4_my ? my4 : s4_yk;
		res_u      <= s4_mx ? mu4 : s4_uk;
		res_v      <= s4_my ? mv4 : s4_vk;
		res_quad   <= s4_quad;
		res_corner <= s4_corner;
		res_last   <= s4_last;
	end

endmodule

// ===== design/filled_sprite_quad_generator_top.sv =====
// Top level of the filled sprite quad generator: configuration registers and wiring.
// Depends on fsqg_pkg, fsqg_issue, fsqg_pipe and the assertion macro header.
//
// Usage. A rectangle (signed Q16.16 corners) and a Q0.16 fill amount are offered on the
// input ports with start high; the transfer happens at a rising edge where start is high
// and busy is low. The block answers with up to sixteen vertices, one per clock, each
// shown for exactly one cycle with result_strobe high; the final vertex of an item has
// last set. Horizontal and vertical fill and a full fill give four vertices, radial fill
// otherwise four per quarter that is not empty; a fill outside range, or the unused
// method code below full fill, gives none. Each vertex passes the sequencer registers,
// then the stage registers s2, s3 and s4 and the result registers. The sequencer issues
// one vertex per cycle, so an item holds the input for as long as it has vertices to
// issue (four or up to sixteen); busy drops in the cycle of its final vertex issue so
// the next item follows without a gap. An item that yields no vertex leaves busy low.
// The vertex pipeline itself has four register stages.
// The configuration port writes fill_method (index 0) or radial_invert (index 1) at any
// edge with cfg_wr_en high; it is meant to be written only while the block is idle.
// Reset clears both registers, the sequencer and all stage valid bits. The receiver
// cannot hold results off; every vertex is a transfer in the cycle it appears.
`include "filled_sprite_quad_generator_top_macros.svh"
module filled_sprite_quad_generator_top import fsqg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] rect_left,
	input  logic signed [31:0] rect_bottom,
	input  logic signed [31:0] rect_right,
	input  logic signed [31:0] rect_top,
	input  logic [16:0]        fill_amount,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [1:0]         cfg_data,
	output logic               result_strobe,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [1:0]         quad_number,
	output logic [1:0]         corner_number,
	output logic               last
);

	logic [1:0] method_q;
	logic       invert_q;
	logic       job_valid;
	job_t       job;

	// Configuration registers keep only their own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_HORIZ;
			invert_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FILL_METHOD:   method_q <= cfg_data;
				REG_RADIAL_INVERT: invert_q <= cfg_data[0];
			endcase
		end
	end

	fsqg_issue u_issue (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.rect_left   (rect_left),
		.rect_bottom (rect_bottom),
		.rect_right  (rect_right),
		.rect_top    (rect_top),
		.fill_amount (fill_amount),
		.method      (method_q),
		.invert      (invert_q),
		.busy        (busy),
		.job_valid   (job_valid),
		.job         (job)
	);

	fsqg_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job),
		.res_valid  (result_strobe),
		.res_x      (pos_x),
		.res_y      (pos_y),
		.res_u      (tex_u),
		.res_v      (tex_v),
		.res_quad   (quad_number),
		.res_corner (corner_number),
		.res_last   (last)
	);

	// The vertices of one item leave in an unbroken run, in corner order.
	`FSQG_ASSERT(a_run_unbroken, result_strobe && !last |=> result_strobe, "vertex run broken")
	`FSQG_ASSERT(a_corner_order, result_strobe && !last |=> corner_number == $past(corner_number) + 2'd1, "corner order broken")
	`FSQG_NEVER(a_last_mid_quad, result_strobe && last && corner_number != 2'd3, "last before quad end")
	`FSQG_ASSERT(a_item_starts, result_strobe && $past(result_strobe && last) |-> corner_number == 2'd0 && quad_number == 2'd0, "item does not start at quad 0 corner 0")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for filled_sprite_quad_generator_top.
// Needs fsqg_pkg and the block's RTL. An in-bench model predicts every vertex,
// and a checker compares each strobed vertex against the oldest prediction.
module tb_top;
	import fsqg_pkg::*;

	// The package names three fill methods. The fourth code is unused, and the
	// block must treat it as "emit only on full fill".
	localparam logic [1:0] METHOD_SPARE = 2'd3;
	localparam longint     UNIT = 64'd1 << FRAC_BITS;
	localparam longint     HALF = UNIT / 2;
	localparam int         STALL_LIMIT = 1000;
	localparam int         SETTLE_CYCLES = 12;

	localparam int TAN_Q16 [17] = '{0, 3220, 6455, 9721, 13036, 16415, 19880, 23450,
		27146, 30994, 35030, 39279, 43790, 48605, 53784, 59398, 65536};

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [16:0] u;
		logic [16:0] v;
		logic [1:0]  quad;
		logic [1:0]  corner;
		logic        fin;
	} vertex_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] rect_left;
	logic signed [31:0] rect_bottom;
	logic signed [31:0] rect_right;
	logic signed [31:0] rect_top;
	logic [16:0]        fill_amount;
	logic               cfg_wr_en;
	logic               cfg_index;
	logic [1:0]         cfg_data;
	logic               result_strobe;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic [1:0]         quad_number;
	logic [1:0]         corner_number;
	logic               last;

	filled_sprite_quad_generator_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.rect_left(rect_left), .rect_bottom(rect_bottom), .rect_right(rect_right),
		.rect_top(rect_top), .fill_amount(fill_amount),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_strobe(result_strobe), .pos_x(pos_x), .pos_y(pos_y),
		.tex_u(tex_u), .tex_v(tex_v), .quad_number(quad_number),
		.corner_number(corner_number), .last(last)
	);

	// Shadow copy of the two configuration registers.
	logic [1:0] model_method;
	logic       model_invert;

	// Vertices that have been predicted but have not been seen on the ports yet.
	vertex_t pending_vertices[$];
	int      error_count;
	int      idle_cycles;
	// When this is set, the sender inserts random gaps between transfers.
	bit      gaps_on;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Interpolate from a to b by the Q0.16 fraction t. The arithmetic shift
	// rounds toward minus infinity.
	function automatic longint lerp(input longint a, input longint b, input longint t);
		return a + (((b - a) * t) >>> FRAC_BITS);
	endfunction

	// Tangent of a * 90 degrees, where a lies in 0..0.5. The table over 0..45
	// degrees is interpolated linearly, and the fractional part is truncated.
	function automatic longint tan_ratio(input longint a);
		longint p;
		longint idx;
		longint frac;
		p    = a << 5;
		idx  = p >> 16;
		frac = p & 64'hFFFF;
		if (idx >= 16) begin
			return 65536;
		end
		return TAN_Q16[idx] + ((longint'(TAN_Q16[idx + 1] - TAN_Q16[idx]) * frac) >> 16);
	endfunction

	// Move the corners of quarter c along the sweep angle. The argument cmp tells
	// which ratio is clipped: 1 means the sine is larger, -1 means the cosine is
	// larger, and 0 is the exact diagonal, where no inner edge moves.
	function automatic void sweep_cut(inout longint x[4], inout longint y[4], input int c,
			input bit inv, input int cmp, input longint cs, input longint sn);
		int p0;
		int p1;
		int p2;
		int p3;
		p0 = c;
		p1 = (c + 1) & 3;
		p2 = (c + 2) & 3;
		p3 = (c + 3) & 3;
		if (c & 1) begin
			if (cmp > 0 && inv) begin
				x[p1] = lerp(x[p0], x[p2], cs);
				x[p2] = x[p1];
			end else if (cmp < 0 && !inv) begin
				y[p2] = lerp(y[p0], y[p2], sn);
				y[p3] = y[p2];
			end
			if (!inv) x[p3] = lerp(x[p0], x[p2], cs);
			else y[p1] = lerp(y[p0], y[p2], sn);
		end else begin
			if (cmp < 0 && !inv) begin
				y[p1] = lerp(y[p0], y[p2], sn);
				y[p2] = y[p1];
			end else if (cmp > 0 && inv) begin
				x[p2] = lerp(x[p0], x[p2], cs);
				x[p3] = x[p2];
			end
			if (inv) y[p3] = lerp(y[p0], y[p2], sn);
			else x[p1] = lerp(x[p0], x[p2], cs);
		end
	endfunction

	// Append the four corners of one quad to the pending list.
	function automatic void push_quad(input longint x[4], input longint y[4],
			input longint u[4], input longint v[4], input int quad);
		vertex_t vtx;
		for (int k = 0; k < 4; k++) begin
			vtx.x      = x[k][31:0];
			vtx.y      = y[k][31:0];
			vtx.u      = u[k][16:0];
			vtx.v      = v[k][16:0];
			vtx.quad   = quad[1:0];
			vtx.corner = k[1:0];
			vtx.fin    = 1'b0;
			pending_vertices.insert(pending_vertices.size(), vtx);
		end
	endfunction

	// Work out every vertex that one accepted rectangle yields and queue them.
	function automatic void predict_vertices(input logic signed [31:0] l,
			input logic signed [31:0] b, input logic signed [31:0] r,
			input logic signed [31:0] t, input logic [16:0] f);
		longint x0, y0, x1, y1, fill, u1, v1, xm, ym, kk, val, a, cs, sn;
		longint px[4], py[4], pu[4], pv[4];
		int     before_count, quads, c, cmp;
		bit     ci;
		x0 = l; y0 = b; x1 = r; y1 = t;
		fill = f;
		u1 = UNIT; v1 = UNIT;
		before_count = pending_vertices.size();
		quads = 0;
		// A fill below 0.001 or above one emits nothing.
		if (fill * 1000 < UNIT || fill > UNIT) begin
			return;
		end
		if (model_method == METHOD_HORIZ) begin
			x1 = lerp(x0, x1, fill);
			u1 = fill;
		end else if (model_method == METHOD_VERT) begin
			y1 = lerp(y0, y1, fill);
			v1 = fill;
		end
		if (fill >= UNIT || model_method == METHOD_HORIZ || model_method == METHOD_VERT) begin
			px = '{x0, x0, x1, x1}; py = '{y0, y1, y1, y0};
			pu = '{0, 0, u1, u1};   pv = '{0, v1, v1, 0};
			push_quad(px, py, pu, pv, 0);
		end else if (model_method == METHOD_RADIAL) begin
			xm = lerp(x0, x1, HALF);
			ym = lerp(y0, y1, HALF);
			for (int bc = 0; bc < 4; bc++) begin
				c   = (bc + 2) & 3;
				kk  = model_invert ? bc : 3 - bc;
				val = fill * 4 - kk * UNIT;
				if (bc < 2) begin
					px = '{x0, x0, xm, xm}; pu = '{0, 0, HALF, HALF};
				end else begin
					px = '{xm, xm, x1, x1}; pu = '{HALF, HALF, UNIT, UNIT};
				end
				if (bc == 0 || bc == 3) begin
					py = '{y0, ym, ym, y0}; pv = '{0, HALF, HALF, 0};
				end else begin
					py = '{ym, y1, y1, ym}; pv = '{HALF, UNIT, UNIT, HALF};
				end
				if (val < 0) val = 0;
				if (val > UNIT) val = UNIT;
				// An empty quarter is skipped, and the later quads take the
				// next quad number.
				if (val * 1000 < UNIT) continue;
				ci = model_invert ^ c[0];
				if (ci || val * 1000 <= 999 * UNIT) begin
					a = ci ? UNIT - val : val;
					cs = UNIT; sn = UNIT; cmp = 0;
					if (a > HALF) begin
						cmp = 1;
						cs = tan_ratio(UNIT - a);
					end else if (a < HALF) begin
						cmp = -1;
						sn = tan_ratio(a);
					end
					sweep_cut(px, py, c, ci, cmp, cs, sn);
					sweep_cut(pu, pv, c, ci, cmp, cs, sn);
				end
				push_quad(px, py, pu, pv, quads);
				quads++;
			end
		end
		if (pending_vertices.size() > before_count) begin
			pending_vertices[pending_vertices.size() - 1].fin = 1'b1;
		end
	endfunction

	// Compare every vertex that the block strobes with the oldest prediction.
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && result_strobe) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: vertex with nothing expected, expected none, actual x=%h y=%h",
					$time, pos_x, pos_y);
				error_count++;
			end else begin
				want = pending_vertices.pop_front();
				if (pos_x !== want.x) begin
					$display("%0t: pos_x expected %h actual %h", $time, want.x, pos_x);
					error_count++;
				end
				if (pos_y !== want.y) begin
					$display("%0t: pos_y expected %h actual %h", $time, want.y, pos_y);
					error_count++;
				end
				if (tex_u !== want.u) begin
					$display("%0t: tex_u expected %h actual %h", $time, want.u, tex_u);
					error_count++;
				end
				if (tex_v !== want.v) begin
					$display("%0t: tex_v expected %h actual %h", $time, want.v, tex_v);
					error_count++;
				end
				if (quad_number !== want.quad) begin
					$display("%0t: quad_number expected %0d actual %0d", $time, want.quad,
						quad_number);
					error_count++;
				end
				if (corner_number !== want.corner) begin
					$display("%0t: corner_number expected %0d actual %0d", $time, want.corner,
						corner_number);
					error_count++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %0d actual %0d", $time, want.fin, last);
					error_count++;
				end
			end
		end
	end

	// The watchdog counts cycles in which no transfer happens on either side.
	// If it reaches the limit, the run has hung and it ends here.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Offer one rectangle and hold it until the block takes it. The prediction
	// is made at the edge of the transfer. Start stays high on return, so the
	// next call either replaces the item or lowers start in the same time step.
	task automatic send_rect(input logic signed [31:0] l, input logic signed [31:0] b,
			input logic signed [31:0] r, input logic signed [31:0] t, input logic [16:0] f);
		if (gaps_on && $urandom_range(99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start       <= 1'b1;
		rect_left   <= l;
		rect_bottom <= b;
		rect_right  <= r;
		rect_top    <= t;
		fill_amount <= f;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predict_vertices(l, b, r, t, f);
	endtask

	// Lower start, then wait until every predicted vertex has arrived. After
	// that, allow a few more cycles, because an item that yields no vertex
	// may still be in flight.
	task automatic drain;
		start <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register while the block is idle, and update the shadow copy.
	// The shadow keeps only the register's width, just as the block does.
	task automatic write_reg(input logic idx, input logic [1:0] data);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_FILL_METHOD) model_method = data;
		else model_invert = data[0];
	endtask

	function automatic logic [31:0] rand_coord;
		// Mostly moderate values; now and then, the full 32-bit range.
		if ($urandom_range(3) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
	endfunction

	function automatic logic [16:0] rand_fill;
		int pick;
		pick = $urandom_range(99);
		if (pick < 6) return 17'($urandom_range(0, 65));
		if (pick < 10) return ONE_V;
		if (pick < 14) return 17'($urandom_range(65537, 131071));
		if (pick < 24) return 17'(($urandom_range(0, 8) * 8192) + $urandom_range(0, 2) - 1);
		return 17'($urandom_range(66, 65535));
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_fill());
		end
	endtask

	// Test horizontal and vertical fill at the edges of the fill range, including
	// the threshold just below 0.001, full fill, excess fill, and extreme corners.
	task automatic test_linear_extremes;
		for (int m = 0; m < 2; m++) begin
			write_reg(REG_FILL_METHOD, m ? METHOD_VERT : METHOD_HORIZ);
			send_rect(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd65);
			send_rect(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd66);
			send_rect(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 17'd40000);
			send_rect(-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, ONE_V);
			send_rect(32'sd0, 32'sd0, 32'sd100, 32'sd100, 17'd65537);
			send_rect(32'sd0, 32'sd0, 32'sd100, 32'sd100, 17'h1FFFF);
			send_rect(32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'h0);
		end
	endtask

	// Test radial fill. Fills land on quarter boundaries and exact diagonals,
	// in both sweep directions, and a swapped rectangle is included.
	task automatic test_radial_cases;
		logic [16:0] fills [7];
		fills = '{17'd8192, 17'd16384, 17'd24576, 17'd32768, 17'd16400, 17'd65535, 17'd66};
		write_reg(REG_FILL_METHOD, METHOD_RADIAL);
		for (int inv = 0; inv < 2; inv++) begin
			// Write 3 to the one-bit register: only bit 0 may be kept.
			write_reg(REG_RADIAL_INVERT, inv ? 2'd3 : 2'd0);
			foreach (fills[i]) begin
				send_rect(-32'sd1048576, -32'sd655360, 32'sd2097152, 32'sd983040, fills[i]);
			end
		end
		send_rect(32'sd500000, 32'sd400000, -32'sd300000, -32'sd200000, 17'd45000);
	endtask

	// Test the unused method code: only a full fill emits anything.
	task automatic test_spare_method;
		write_reg(REG_FILL_METHOD, METHOD_SPARE);
		send_rect(32'sd1, 32'sd2, 32'sd3, 32'sd4, 17'd30000);
		send_rect(32'sd1, 32'sd2, 32'sd300000, 32'sd400000, ONE_V);
	endtask

	// Random rectangles under each register setting. One phase runs with no
	// gaps, so the block also sees back-to-back transfers.
	task automatic test_random_sweep;
		write_reg(REG_FILL_METHOD, METHOD_HORIZ);
		run_random(70);
		write_reg(REG_FILL_METHOD, METHOD_VERT);
		run_random(70);
		write_reg(REG_FILL_METHOD, METHOD_RADIAL);
		write_reg(REG_RADIAL_INVERT, 2'd0);
		run_random(100);
		gaps_on = 1'b0;
		run_random(80);
		gaps_on = 1'b1;
		write_reg(REG_RADIAL_INVERT, 2'd1);
		run_random(100);
		write_reg(REG_FILL_METHOD, METHOD_SPARE);
		run_random(40);
		drain();
	endtask

	initial begin
		error_count = 0;
		model_method = METHOD_HORIZ;
		model_invert = 1'b0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		rect_left = '0;
		rect_bottom = '0;
		rect_right = '0;
		rect_top = '0;
		fill_amount = '0;
		cfg_wr_en = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_linear_extremes();
		test_radial_cases();
		test_spare_method();
		test_random_sweep();
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
